// File: rtl/ncr_pkg.sv
// ncr_pkg: field widths, status and register codes, saturation limits and
// small helpers shared by the cubic root solver and its channel interfaces.
// no dependencies
package ncr_pkg;

  localparam int IN_W       = 32;
  localparam int ROOT_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int ITER_W     = 8;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // intermediates live within +-2^61
  localparam int VAL_W  = 63;
  localparam int MAG_W  = 62;
  localparam int HALF_W = 31;
  localparam int PROD_W = 2 * MAG_W;
  localparam int EXT_W  = 65;

  localparam logic [MAG_W-1:0] LIM_U  = 62'h2000_0000_0000_0000;
  localparam logic [MAG_W-1:0] SQ_SAT = LIM_U / 9;
  localparam logic signed [EXT_W-1:0] EXT_LIM  = $signed({3'b000, LIM_U});
  localparam logic signed [EXT_W-1:0] EXT_NLIM = -EXT_LIM;

  localparam logic [STATUS_W-1:0] ST_TOL        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXACT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_SLOPE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIMIT      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET      = 31'd66;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd20;

  function automatic logic [MAG_W-1:0] mag(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] n;
    n = -v;
    return v[VAL_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_lim(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] c;
    if (v > EXT_LIM) begin
      c = EXT_LIM;
    end else if (v < EXT_NLIM) begin
      c = EXT_NLIM;
    end else begin
      c = v;
    end
    return c[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/ncr_bracket_if.sv
// ncr_bracket_if: input channel carrying one bracket item
// depends on ncr_pkg
interface ncr_bracket_if import ncr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] lower_bound;
  logic signed [IN_W-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

// File: rtl/ncr_result_if.sv
// ncr_result_if: output channel carrying root, status and step count
// depends on ncr_pkg
interface ncr_result_if import ncr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ROOT_W-1:0] root;
  logic [STATUS_W-1:0]      status;
  logic [ITER_W-1:0]        iterations_used;

  modport source (output valid, output root, output status, output iterations_used,
                  input ready);
  modport sink   (input valid, input root, input status, input iterations_used,
                  output ready);
endinterface

// File: rtl/ncr_cfg_if.sv
// ncr_cfg_if: register write channel, index and data
// depends on ncr_pkg
interface ncr_cfg_if import ncr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/newton_cubic_root_solver.sv
// newton_cubic_root_solver: Newton root finder for f(x) = 3x^3 - 2x - 5
// depends on ncr_pkg, ncr_bracket_if, ncr_result_if, ncr_cfg_if
//
// One bracket item is taken at a time and bracket.ready stays low until the
// result has been moved into the output register, which then waits for the
// sink while the next item can already enter. Products go through one shared
// 31x31 multiplier over four partial products, and the Newton quotient
// through a restoring divider that produces one quotient bit a cycle.
// Registers are to be written through cfg only while the block is idle; the
// block itself does not enforce this. cfg.ready is always high.
module newton_cubic_root_solver import ncr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  ncr_bracket_if.sink  bracket,
  ncr_result_if.source result,
  ncr_cfg_if.sink      cfg
);

  localparam int FX_W   = (WORD_BITS > IN_W) ? WORD_BITS : IN_W;
  localparam int NUM_W  = MAG_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam logic signed [EXT_W-1:0] FIVE = $signed(EXT_W'(5)) <<< FRAC_BITS;
  localparam logic signed [VAL_W-1:0] TWO  = $signed(VAL_W'(2)) <<< FRAC_BITS;
  localparam logic signed [EXT_W-1:0] WMAX =
    ($signed(EXT_W'(1)) <<< (WORD_BITS - 1)) - $signed(EXT_W'(1));
  localparam logic signed [EXT_W-1:0] WMIN = -WMAX - $signed(EXT_W'(1));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FV_SQ = 4'd1;
  localparam logic [3:0] S_FV_CU = 4'd2;
  localparam logic [3:0] S_FV_T  = 4'd3;
  localparam logic [3:0] S_FV_F  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_MULR  = 4'd6;
  localparam logic [3:0] S_CHK_A = 4'd7;
  localparam logic [3:0] S_CHK_B = 4'd8;
  localparam logic [3:0] S_IT_G  = 4'd9;
  localparam logic [3:0] S_IT_GZ = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_DIVR  = 4'd12;
  localparam logic [3:0] S_IT_X1 = 4'd13;
  localparam logic [3:0] S_IT_CK = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  function automatic logic signed [WORD_BITS-1:0] clamp_word(
    input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] c;
    if (v > WMAX) begin
      c = WMAX;
    end else if (v < WMIN) begin
      c = WMIN;
    end else begin
      c = v;
    end
    return c[WORD_BITS-1:0];
  endfunction

  logic [3:0] state;
  logic [3:0] mul_ret;
  logic [3:0] fv_ret;

  logic [TOL_W-1:0]  tolerance;
  logic [ITER_W-1:0] max_iter;

  logic signed [IN_W-1:0]      lo;
  logic signed [IN_W-1:0]      hi;
  logic signed [FX_W-1:0]      fx;
  logic signed [WORD_BITS-1:0] x0;
  logic signed [WORD_BITS-1:0] x1;
  logic signed [VAL_W-1:0]     sq;
  logic signed [VAL_W-1:0]     f;
  logic signed [VAL_W-1:0]     g;
  logic signed [VAL_W-1:0]     fv_t;
  logic signed [VAL_W-1:0]     mul_res;
  logic signed [VAL_W-1:0]     dq;
  logic                        fa_pos;
  logic                        fa_neg;
  logic [ITER_W-1:0]           iter;
  logic [ITER_W-1:0]           used;
  logic [STATUS_W-1:0]         fin_status;

  logic [MAG_W-1:0]  mul_am;
  logic [MAG_W-1:0]  mul_bm;
  logic              mul_neg;
  logic [2:0]        mcnt;
  logic [MAG_W-1:0]  pp;
  logic [1:0]        pk;
  logic [PROD_W-1:0] acc;

  logic [NUM_W-1:0]  dnum;
  logic [MAG_W-1:0]  dden;
  logic [MAG_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic              div_neg;
  logic [DCNT_W-1:0] dcnt;

  logic                     out_valid;
  logic signed [ROOT_W-1:0] root_q;
  logic [STATUS_W-1:0]      status_q;
  logic [ITER_W-1:0]        iters_q;

  // shared multiplier
  logic [HALF_W-1:0]       a_half;
  logic [HALF_W-1:0]       b_half;
  logic [MAG_W-1:0]        pp_next;
  logic [PROD_W-1:0]       pp_sh;
  logic [PROD_W-1:0]       acc_sh;
  logic [MAG_W-1:0]        mul_mag;
  logic signed [VAL_W-1:0] mul_val;

  assign a_half  = mcnt[1] ? mul_am[MAG_W-1:HALF_W] : mul_am[HALF_W-1:0];
  assign b_half  = mcnt[0] ? mul_bm[MAG_W-1:HALF_W] : mul_bm[HALF_W-1:0];
  assign pp_next = MAG_W'(a_half) * MAG_W'(b_half);

  always_comb begin
    case (pk)
      2'd0: pp_sh = PROD_W'(pp);
      2'd1: pp_sh = PROD_W'(pp) << HALF_W;
      2'd2: pp_sh = PROD_W'(pp) << HALF_W;
      2'd3: pp_sh = PROD_W'(pp) << (2 * HALF_W);
      default: pp_sh = '0;
    endcase
  end

  assign acc_sh  = acc >> FRAC_BITS;
  assign mul_mag = (acc_sh > PROD_W'(LIM_U)) ? LIM_U : acc_sh[MAG_W-1:0];
  assign mul_val = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});

  // f and f' evaluation
  logic signed [VAL_W-1:0] fx_val;
  logic signed [EXT_W-1:0] cube3;
  logic signed [VAL_W-1:0] t_next;
  logic signed [VAL_W-1:0] f_next;
  logic signed [VAL_W-1:0] sq9;
  logic signed [VAL_W-1:0] g_next;

  assign fx_val = VAL_W'(fx);
  assign cube3  = EXT_W'(mul_res) + (EXT_W'(mul_res) <<< 1);
  assign t_next = clamp_lim(EXT_W'(clamp_lim(cube3)) - (EXT_W'(fx) <<< 1));
  assign f_next = clamp_lim(EXT_W'(fv_t) - FIVE);
  assign sq9    = (sq > $signed({1'b0, SQ_SAT})) ? $signed({1'b0, LIM_U}) : (sq <<< 3) + sq;
  assign g_next = sq9 - TWO;

  // bracket check and midpoint
  logic signed [IN_W:0]        sum33;
  logic signed [IN_W:0]        half33;
  logic signed [WORD_BITS-1:0] mid;
  logic                        bad_range;

  assign sum33  = $signed({lo[IN_W-1], lo}) + $signed({hi[IN_W-1], hi});
  assign half33 = (sum33 + $signed({{IN_W{1'b0}}, sum33[IN_W]})) >>> 1;
  assign mid    = clamp_word(EXT_W'(half33));
  assign bad_range = (hi <= lo) ||
                     !((fa_pos && f[VAL_W-1]) || (fa_neg && (f > 0)));

  // divider
  logic [MAG_W:0]          r2;
  logic                    r2_ge;
  logic [MAG_W:0]          r2_sub;
  logic [MAG_W-1:0]        quo_mag;
  logic signed [VAL_W-1:0] dq_next;

  assign r2      = {rem, dnum[NUM_W-1]};
  assign r2_ge   = r2 >= {1'b0, dden};
  assign r2_sub  = r2 - {1'b0, dden};
  assign quo_mag = (quo > NUM_W'(LIM_U)) ? LIM_U : quo[MAG_W-1:0];
  assign dq_next = div_neg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});

  // step update and stop tests
  logic signed [WORD_BITS-1:0] x1_next;
  logic [MAG_W-1:0]            f_mag;
  logic [ITER_W-1:0]           limit;
  logic signed [FX_W-1:0]      x1_ext;

  assign x1_next = clamp_word(EXT_W'(x0) - EXT_W'(dq));
  assign f_mag   = mag(f);
  assign limit   = (max_iter == '0) ? ITER_W'(1) : max_iter;
  assign x1_ext  = FX_W'(x1);

  assign bracket.ready          = (state == S_IDLE);
  assign cfg.ready              = 1'b1;
  assign result.valid           = out_valid;
  assign result.root            = root_q;
  assign result.status          = status_q;
  assign result.iterations_used = iters_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      tolerance <= TOL_RESET;
      max_iter  <= MAX_ITER_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TOLERANCE: tolerance <= cfg.data;
          REG_MAX_ITER:  max_iter  <= cfg.data[ITER_W-1:0];
          default: ;
        endcase
      end

      if ((state == S_FIN) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (bracket.valid) begin
            lo     <= bracket.lower_bound;
            hi     <= bracket.upper_bound;
            fx     <= FX_W'(bracket.lower_bound);
            fv_ret <= S_CHK_A;
            state  <= S_FV_SQ;
          end
        end
        S_FV_SQ: begin
          mul_am  <= mag(fx_val);
          mul_bm  <= mag(fx_val);
          mul_neg <= 1'b0;
          acc     <= '0;
          mcnt    <= '0;
          mul_ret <= S_FV_CU;
          state   <= S_MUL;
        end
        S_FV_CU: begin
          sq      <= mul_res;
          mul_am  <= mag(mul_res);
          mul_bm  <= mag(fx_val);
          mul_neg <= mul_res[VAL_W-1] ^ fx[FX_W-1];
          acc     <= '0;
          mcnt    <= '0;
          mul_ret <= S_FV_T;
          state   <= S_MUL;
        end
        S_FV_T: begin
          fv_t  <= t_next;
          state <= S_FV_F;
        end
        S_FV_F: begin
          f     <= f_next;
          state <= fv_ret;
        end
        S_MUL: begin
          if (mcnt != 3'd4) begin
            pp <= pp_next;
            pk <= mcnt[1:0];
          end
          if (mcnt != 3'd0) begin
            acc <= acc + pp_sh;
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) begin
            state <= S_MULR;
          end
        end
        S_MULR: begin
          mul_res <= mul_val;
          state   <= mul_ret;
        end
        S_CHK_A: begin
          fa_pos <= (f > 0);
          fa_neg <= f[VAL_W-1];
          fx     <= FX_W'(hi);
          fv_ret <= S_CHK_B;
          state  <= S_FV_SQ;
        end
        S_CHK_B: begin
          if (bad_range) begin
            x1         <= '0;
            used       <= '0;
            fin_status <= ST_BAD_RANGE;
            state      <= S_FIN;
          end else begin
            x0     <= mid;
            fx     <= FX_W'(mid);
            iter   <= ITER_W'(1);
            fv_ret <= S_IT_G;
            state  <= S_FV_SQ;
          end
        end
        S_IT_G: begin
          g     <= g_next;
          state <= S_IT_GZ;
        end
        S_IT_GZ: begin
          if (g == '0) begin
            x1         <= x0;
            used       <= iter - ITER_W'(1);
            fin_status <= ST_ZERO_SLOPE;
            state      <= S_FIN;
          end else begin
            dnum    <= NUM_W'(mag(f)) << FRAC_BITS;
            dden    <= mag(g);
            div_neg <= f[VAL_W-1] ^ g[VAL_W-1];
            rem     <= '0;
            quo     <= '0;
            dcnt    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (r2_ge) begin
            rem <= r2_sub[MAG_W-1:0];
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= r2[MAG_W-1:0];
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          dnum <= dnum << 1;
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(NUM_W - 1)) begin
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          dq    <= dq_next;
          state <= S_IT_X1;
        end
        S_IT_X1: begin
          x1     <= x1_next;
          fx     <= FX_W'(x1_next);
          fv_ret <= S_IT_CK;
          state  <= S_FV_SQ;
        end
        S_IT_CK: begin
          used <= iter;
          if (f == '0) begin
            fin_status <= ST_EXACT;
            state      <= S_FIN;
          end else if (f_mag <= MAG_W'(tolerance)) begin
            fin_status <= ST_TOL;
            state      <= S_FIN;
          end else if (iter >= limit) begin
            fin_status <= ST_LIMIT;
            state      <= S_FIN;
          end else begin
            x0    <= x1;
            iter  <= iter + ITER_W'(1);
            state <= S_IT_G;
          end
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            root_q   <= x1_ext[ROOT_W-1:0];
            status_q <= fin_status;
            iters_q  <= used;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/tb_newton_cubic_root_solver.sv
`timescale 1ns / 1ps
// tb_newton_cubic_root_solver: drives brackets into the cubic root solver and checks
// root, status and step count against a bit-exact fixed-point Newton predictor
// depends on ncr_pkg, ncr_bracket_if, ncr_result_if, ncr_cfg_if and the solver
module tb_newton_cubic_root_solver;
  import ncr_pkg::*;

  localparam int          FRAC             = FRAC_BITS_DEF;
  localparam longint      ONE_Q            = 64'sd1 <<< FRAC;
  localparam int          ONE_I            = 1 << FRAC;
  localparam longint      LIM_S            = 64'sh2000_0000_0000_0000;
  localparam logic [63:0] LIM_MAG          = 64'h2000_0000_0000_0000;
  localparam longint      WORD_MAX         = (64'sd1 <<< (WORD_BITS_DEF - 1)) - 1;
  localparam longint      WORD_MIN         = -WORD_MAX - 1;
  localparam int          ROOT_NEAR        = 89900;
  localparam int          LONG_HOLD_CYCLES = 3000;
  localparam int          DRAIN_CYCLES     = 400;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root;
    logic [STATUS_W-1:0]      status;
    logic [ITER_W-1:0]        iterations_used;
  } solution_t;

  typedef struct packed {
    logic signed [IN_W-1:0] lower;
    logic signed [IN_W-1:0] upper;
    logic                   has_known;
    solution_t              known;
  } bracket_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  localparam solution_t BAD_SOL  = '{root: '0, status: ST_BAD_RANGE, iterations_used: '0};
  localparam solution_t PREDICT  = '0;

  localparam int N_DIRECTED = 19;
  localparam bracket_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, PREDICT},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, BAD_SOL},
    '{32'sh0000_0000, 32'sh0000_0000, 1'b1, BAD_SOL},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, BAD_SOL},
    '{32'sh8000_0000, 32'sh8000_0000, 1'b1, BAD_SOL},
    '{32'sh0000_0000, 32'sh0002_0000, 1'b0, PREDICT},
    '{32'sh0002_0000, 32'sh0003_0000, 1'b1, BAD_SOL},
    '{-32'sh0003_0000, -32'sh0001_0000, 1'b1, BAD_SOL},
    '{32'sh0001_0000, 32'sh0002_0000, 1'b0, PREDICT},
    '{ROOT_NEAR - 1, ROOT_NEAR + 1, 1'b0, PREDICT},
    // midpoints where the slope is close to zero
    '{-32'sd29106, 32'sd90894, 1'b0, PREDICT},
    '{-32'sd151788, 32'sd90000, 1'b0, PREDICT},
    '{32'sh8000_0000, 32'sh0002_0000, 1'b0, PREDICT},
    // far midpoint, runs into the step limit
    '{32'sh0000_0000, 32'sh7FFF_FFFF, 1'b0, PREDICT},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, PREDICT},
    '{32'shFFFF_FFFF, 32'sh4000_0000, 1'b0, PREDICT},
    '{ROOT_NEAR, ROOT_NEAR, 1'b1, BAD_SOL},
    '{32'sh0002_0000, 32'sh0001_0000, 1'b1, BAD_SOL},
    '{-32'sh0001_0000, 32'sh0001_8000, 1'b0, PREDICT}
  };

  logic clk;
  logic rst;

  ncr_bracket_if bracket_ch ();
  ncr_result_if  result_ch ();
  ncr_cfg_if     cfg_ch ();

  newton_cubic_root_solver dut (
    .clk     (clk),
    .rst     (rst),
    .bracket (bracket_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  logic [TOL_W-1:0]  tol_setting;
  logic [ITER_W-1:0] iter_limit_setting;
  solution_t         solutions_due [$];
  int                in_flight;
  int                items_sent;
  int                settings_used;
  int                check_failures;
  int                burst_left;
  int                status_seen [0:7];
  bit                long_hold;

  // fixed-point arithmetic of the solver

  function automatic longint clamp61(input longint v);
    if (v > LIM_S) return LIM_S;
    if (v < -LIM_S) return -LIM_S;
    return v;
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    return clamp61(clamp61(a) + clamp61(b));
  endfunction

  function automatic longint mul_q(input longint a, input longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = ({64'd0, ua} * {64'd0, ub}) >> FRAC;
    if (p > {64'd0, LIM_MAG}) p = {64'd0, LIM_MAG};
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint div_q(input longint n, input longint d);
    logic [63:0]  un;
    logic [63:0]  ud;
    logic [127:0] q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    if (un / ud > (LIM_MAG >> FRAC)) begin
      q = {64'd0, LIM_MAG};
    end else begin
      q = ({64'd0, un} << FRAC) / {64'd0, ud};
      if (q > {64'd0, LIM_MAG}) q = {64'd0, LIM_MAG};
    end
    return ((n < 0) != (d < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint f_cubic(input longint x);
    longint sq;
    longint cu;
    longint t;
    sq = mul_q(x, x);
    cu = mul_q(sq, x);
    t = add_sat(add_sat(cu, cu), cu);
    t = add_sat(t, -2 * x);
    return add_sat(t, -5 * ONE_Q);
  endfunction

  function automatic longint f_slope(input longint x);
    longint sq;
    longint n;
    sq = mul_q(x, x);
    n = (sq > LIM_S / 9) ? LIM_S : 9 * sq;
    return n - 2 * ONE_Q;
  endfunction

  function automatic solution_t solve_bracket(input logic signed [IN_W-1:0] lo,
                                              input logic signed [IN_W-1:0] hi);
    solution_t sol;
    longint    a;
    longint    b;
    longint    fa;
    longint    fb;
    longint    x0;
    longint    x1;
    longint    f1;
    longint    g0;
    longint    limit;
    longint    step;
    a = lo;
    b = hi;
    fa = f_cubic(a);
    fb = f_cubic(b);
    sol = BAD_SOL;
    if (b <= a || fa == 0 || fb == 0 || ((fa < 0) == (fb < 0))) return sol;
    x0 = clamp_word((a + b) / 2);
    x1 = 0;
    limit = (iter_limit_setting == 0) ? 1 : longint'(iter_limit_setting);
    sol.status = ST_LIMIT;
    sol.iterations_used = '0;
    for (step = 1; step <= limit; step++) begin
      g0 = f_slope(x0);
      if (g0 == 0) begin
        x1 = x0;
        sol.status = ST_ZERO_SLOPE;
        sol.iterations_used = ITER_W'(step - 1);
        break;
      end
      x1 = clamp_word(x0 - div_q(f_cubic(x0), g0));
      f1 = f_cubic(x1);
      sol.iterations_used = ITER_W'(step);
      if (f1 == 0) begin
        sol.status = ST_EXACT;
        break;
      end
      if (((f1 < 0) ? -f1 : f1) <= longint'(tol_setting)) begin
        sol.status = ST_TOL;
        break;
      end
      x0 = x1;
    end
    sol.root = x1[ROOT_W-1:0];
    return sol;
  endfunction

  // stimulus

  function automatic void draw_bracket(output logic signed [IN_W-1:0] lo,
                                       output logic signed [IN_W-1:0] hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      lo = ROOT_NEAR - $urandom_range(1, 4 * ONE_I);
      hi = ROOT_NEAR + $urandom_range(1, 4 * ONE_I);
    end else if (roll < 70) begin
      lo = ROOT_NEAR - $urandom_range(1, 1 << 24);
      hi = ROOT_NEAR + $urandom_range(1, 1 << 24);
    end else if (roll < 80) begin
      lo = {1'b1, 31'($urandom)};
      hi = $urandom_range(ROOT_NEAR + 1, 32'h7FFF_FFFF);
    end else if (roll < 85) begin
      lo = ROOT_NEAR + $urandom_range(0, 4 * ONE_I);
      hi = ($urandom_range(0, 1) == 1) ? lo : ROOT_NEAR - $urandom_range(0, 4 * ONE_I);
    end else begin
      lo = $urandom;
      hi = $urandom;
    end
  endfunction

  // enter at a falling edge, leave at a falling edge
  task automatic offer_bracket(input logic signed [IN_W-1:0] lo,
                               input logic signed [IN_W-1:0] hi,
                               input logic has_known, input solution_t known);
    solution_t want;
    int        gap;
    int        roll;
    want = has_known ? known : solve_bracket(lo, hi);
    bracket_ch.lower_bound <= lo;
    bracket_ch.upper_bound <= hi;
    bracket_ch.valid       <= 1'b1;
    do @(posedge clk); while (!bracket_ch.ready);
    solutions_due.push_back(want);
    in_flight++;
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      roll = $urandom_range(0, 99);
      gap = (roll < 25) ? 0 : (roll < 85) ? $urandom_range(1, 8) : $urandom_range(9, 60);
      if (gap > 0) begin
        bracket_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic run_phase(input int count);
    logic signed [IN_W-1:0] lo;
    logic signed [IN_W-1:0] hi;
    for (int i = 0; i < count; i++) begin
      draw_bracket(lo, hi);
      offer_bracket(lo, hi, 1'b0, PREDICT);
    end
    bracket_ch.valid <= 1'b0;
    wait (in_flight == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_TOLERANCE) begin
      tol_setting = value[TOL_W-1:0];
    end else begin
      iter_limit_setting = value[ITER_W-1:0];
    end
    @(negedge clk);
  endtask

  // block is idle here: every result has been taken
  task automatic set_limits(input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] max_steps);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_MAX_ITER, {23'($urandom), max_steps});
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // result sink with its own stall pattern and one long hold
  initial begin
    int       seg_left;
    rx_mode_e mode;
    result_ch.ready = 1'b0;
    seg_left = 0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      if (seg_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 300);
      end
      seg_left--;
      case (mode)
        RX_OPEN:     result_ch.ready <= 1'b1;
        RX_RANDOM:   result_ch.ready <= ($urandom_range(0, 3) != 0);
        default:     result_ch.ready <= ((seg_left % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    solution_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (solutions_due.size() == 0) begin
        $error("result with no bracket outstanding: root %0d status %0d",
               $signed(result_ch.root), result_ch.status);
        check_failures++;
      end else begin
        want = solutions_due.pop_front();
        in_flight--;
        status_seen[result_ch.status]++;
        if (result_ch.root !== want.root) begin
          $error("root mismatch: expected %0d, got %0d", $signed(want.root),
                 $signed(result_ch.root));
          check_failures++;
        end
        if (result_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, result_ch.status);
          check_failures++;
        end
        if (result_ch.iterations_used !== want.iterations_used) begin
          $error("iterations_used mismatch: expected %0d, got %0d", want.iterations_used,
                 result_ch.iterations_used);
          check_failures++;
        end
      end
    end
  end

  initial begin
    int probe;
    int zero_at;
    bit zero_found;
    rst = 1'b1;
    bracket_ch.valid       = 1'b0;
    bracket_ch.lower_bound = '0;
    bracket_ch.upper_bound = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TOLERANCE;
    cfg_ch.data  = '0;
    tol_setting        = TOL_RESET;
    iter_limit_setting = MAX_ITER_RESET;
    in_flight      = 0;
    items_sent     = 0;
    settings_used  = 1;
    check_failures = 0;
    burst_left     = 0;
    long_hold      = 1'b0;
    zero_at        = 0;
    zero_found     = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_bracket(DIRECTED_ROWS[i].lower, DIRECTED_ROWS[i].upper,
                    DIRECTED_ROWS[i].has_known, DIRECTED_ROWS[i].known);
    end

    // bracket ends sitting exactly on a zero of f, if the fixed-point f has one
    for (probe = ROOT_NEAR - 4000; probe <= ROOT_NEAR + 4000; probe++) begin
      if (!zero_found && f_cubic(probe) == 0) begin
        zero_at = probe;
        zero_found = 1'b1;
      end
    end
    if (zero_found) begin
      offer_bracket(zero_at, zero_at + ONE_I, 1'b1, BAD_SOL);
      offer_bracket(zero_at - ONE_I, zero_at, 1'b1, BAD_SOL);
      offer_bracket(zero_at - 3, zero_at + 5, 1'b0, PREDICT);
    end

    long_hold = 1'b1;
    run_phase(260);
    set_limits(31'd0, 8'd8);
    run_phase(130);
    set_limits(31'h7FFF_FFFF, 8'd255);
    run_phase(30);
    set_limits(31'($urandom_range(0, 500)), 8'd0);
    run_phase(120);
    set_limits(31'($urandom_range(0, 1 << 20)), 8'd1);
    run_phase(100);
    set_limits(31'($urandom_range(1, 4000)), 8'($urandom_range(2, 40)));
    run_phase(200);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d brackets over %0d limit settings", items_sent, settings_used);
    $display("summary: %0d within tolerance, %0d exact, %0d bad bracket, %0d at step limit",
             status_seen[ST_TOL], status_seen[ST_EXACT], status_seen[ST_BAD_RANGE],
             status_seen[ST_LIMIT]);
    if (check_failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
